// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros shared by the checkers of this block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, muted while reset is high
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, muted while reset is high
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

// next-cycle implication that also covers reset itself
`define ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg
// types, codes and sizes shared by the bounded sorted deque
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

   localparam int DEPTH   = 16;
   localparam int ELEM_W  = 32;
   localparam int COUNT_W = 5;
   localparam int FILL_W  = $clog2(DEPTH + 1);
   localparam int IDX_W   = $clog2(DEPTH);

   typedef enum logic [2:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_REVERSE    = 3'd3,
      KIND_INSERT     = 3'd4,
      KIND_DUMP       = 3'd5
   } bsd_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_DUP   = 2'd3
   } bsd_status_type;

   typedef struct packed {
      bsd_kind_type             kind;
      logic signed [ELEM_W-1:0] value;
   } bsd_req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
      logic [COUNT_W-1:0]       count;
      bsd_status_type           status;
      logic                     last;
   } bsd_rsp_type;

   // what every cell of the row does in the coming cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_LOW,
      CELL_WRITE_FILL,
      CELL_SHIFT_DOWN,
      CELL_INSERT_FWD,
      CELL_INSERT_REV,
      CELL_ROT_DOWN,
      CELL_ROT_UP
   } bsd_cell_op_type;

   typedef struct packed {
      bsd_cell_op_type   op;
      logic              rev;
      logic [ELEM_W-1:0] value;
      logic [ELEM_W-1:0] front;
      logic [FILL_W-1:0] fill;
   } bsd_cell_ctrl_type;

   // what a cell shows its neighbours and the reduction
   typedef struct packed {
      logic [ELEM_W-1:0] val;
      logic              ge;
      logic              below_or;
      logic              above_or;
      logic              dup;
      logic              tail;
   } bsd_cell_out_type;

   typedef struct packed {
      logic [ELEM_W-1:0] front;
      logic              dup;
   } bsd_chain_status_type;

   // edge of the row below cell 0: counts as not less, so a reversed insert
   // with no match lands in cell 0
   localparam bsd_cell_out_type LEFT_EDGE = '{
      val: '0, ge: 1'b1, below_or: 1'b0, above_or: 1'b0, dup: 1'b0, tail: 1'b0
   };

   localparam bsd_cell_out_type RIGHT_EDGE = '{
      val: '0, ge: 1'b0, below_or: 1'b0, above_or: 1'b0, dup: 1'b0, tail: 1'b0
   };

endpackage

`default_nettype wire

// ===== sv/bsd_cell.sv =====
// ----------------------------------------------------------------------------
// bsd_cell
// one list element with its compare and neighbour shift logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsd_cell (
   input  wire                          clock,
   input  wire [bsd_pkg::IDX_W-1:0]     idx,
   input  bsd_pkg::bsd_cell_ctrl_type   ctrl,
   input  bsd_pkg::bsd_cell_out_type    left,
   input  bsd_pkg::bsd_cell_out_type    right,
   output bsd_pkg::bsd_cell_out_type    cell_out
);
   import bsd_pkg::*;

   logic [ELEM_W-1:0] val_ff;
   logic [ELEM_W-1:0] val_in;
   logic [FILL_W-1:0] pos;
   logic              occ;
   logic              at_fill;
   logic              tail;
   logic              is_first;
   logic              ge;
   logic              eq;
   logic              mark;
   logic              above;

   always_comb begin
      pos      = FILL_W'(idx);
      occ      = pos < ctrl.fill;
      at_fill  = pos == ctrl.fill;
      tail     = (pos + FILL_W'(1)) == ctrl.fill;
      is_first = idx == '0;
      ge       = occ && !($signed(val_ff) < $signed(ctrl.value));
      eq       = val_ff == ctrl.value;
      mark     = ge || at_fill;
      above    = ge || right.above_or;
   end

   always_comb begin
      val_in = val_ff;
      case (ctrl.op)
         CELL_HOLD:       val_in = val_ff;
         CELL_PUSH_LOW:   val_in = is_first ? ctrl.value : left.val;
         CELL_WRITE_FILL: val_in = at_fill ? ctrl.value : val_ff;
         CELL_SHIFT_DOWN: val_in = right.val;
         CELL_INSERT_FWD: begin
            if (left.below_or) val_in = left.val;
            else if (mark)     val_in = ctrl.value;
         end
         CELL_INSERT_REV: begin
            if (!above) val_in = left.ge ? ctrl.value : left.val;
         end
         CELL_ROT_DOWN:   val_in = tail ? ctrl.front : right.val;
         CELL_ROT_UP:     val_in = is_first ? ctrl.front : left.val;
         default:         val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   always_comb begin
      cell_out.val      = val_ff;
      cell_out.ge       = ge;
      cell_out.below_or = left.below_or || mark;
      cell_out.above_or = above;
      cell_out.dup      = ge && eq && (ctrl.rev ? !right.above_or : !left.below_or);
      cell_out.tail     = tail;
   end

endmodule

`default_nettype wire

// ===== sv/bsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsd_ctrl
// input holding register, operation sequencer, fill count and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsd_ctrl (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  bsd_pkg::bsd_req_type           req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output bsd_pkg::bsd_rsp_type           rsp_data,
   input  bsd_pkg::bsd_chain_status_type  chain,
   output bsd_pkg::bsd_cell_ctrl_type     cell_ctrl
);
   import bsd_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_REPORT,
      S_DUMP
   } state_type;

   state_type         state_ff,      state_in;
   logic              hold_valid_ff, hold_valid_in;
   bsd_req_type       hold_ff,       hold_in;
   logic [FILL_W-1:0] fill_ff,       fill_in;
   logic              rev_ff,        rev_in;
   logic [FILL_W-1:0] cnt_ff,        cnt_in;
   bsd_status_type    st_ff,         st_in;
   logic              rsp_valid_ff,  rsp_valid_in;
   bsd_rsp_type       rsp_data_ff,   rsp_data_in;

   bsd_cell_op_type   op;
   logic              full;
   logic              empty;
   logic              out_free;
   logic              take;
   logic              req_accept;

   always_comb begin
      full       = fill_ff == FILL_W'(DEPTH);
      empty      = fill_ff == '0;
      out_free   = !rsp_valid_ff || !rsp_stall;
      take       = hold_valid_ff && (state_ff == S_IDLE);
      req_stall  = hold_valid_ff && (state_ff != S_IDLE);
      req_accept = req_valid && !req_stall;
   end

   always_comb begin
      state_in      = state_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      fill_in       = fill_ff;
      rev_in        = rev_ff;
      cnt_in        = cnt_ff;
      st_in         = st_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      op            = CELL_HOLD;

      case (state_ff)
         S_IDLE: begin
            if (hold_valid_ff) begin
               st_in    = STATUS_OK;
               state_in = S_REPORT;
               case (hold_ff.kind)
                  KIND_PUSH_FRONT: begin
                     if (full) begin
                        st_in = STATUS_FULL;
                     end else begin
                        op      = rev_ff ? CELL_WRITE_FILL : CELL_PUSH_LOW;
                        fill_in = fill_ff + FILL_W'(1);
                     end
                  end
                  KIND_PUSH_BACK: begin
                     if (full) begin
                        st_in = STATUS_FULL;
                     end else begin
                        op      = rev_ff ? CELL_PUSH_LOW : CELL_WRITE_FILL;
                        fill_in = fill_ff + FILL_W'(1);
                     end
                  end
                  KIND_POP_FRONT: begin
                     if (empty) begin
                        st_in = STATUS_EMPTY;
                     end else begin
                        op      = rev_ff ? CELL_HOLD : CELL_SHIFT_DOWN;
                        fill_in = fill_ff - FILL_W'(1);
                     end
                  end
                  KIND_REVERSE: begin
                     rev_in = !rev_ff;
                  end
                  KIND_INSERT: begin
                     if (chain.dup) begin
                        st_in = STATUS_DUP;
                     end else if (full) begin
                        st_in = STATUS_FULL;
                     end else begin
                        op      = rev_ff ? CELL_INSERT_REV : CELL_INSERT_FWD;
                        fill_in = fill_ff + FILL_W'(1);
                     end
                  end
                  KIND_DUMP: begin
                     if (empty) begin
                        st_in = STATUS_EMPTY;
                     end else begin
                        state_in = S_DUMP;
                        cnt_in   = fill_ff;
                     end
                  end
                  default: begin
                     st_in = STATUS_OK;
                  end
               endcase
            end
         end
         S_REPORT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.element = empty ? '0 : chain.front;
               rsp_data_in.count   = COUNT_W'(fill_ff);
               rsp_data_in.status  = st_ff;
               rsp_data_in.last    = 1'b1;
               state_in            = S_IDLE;
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.element = chain.front;
               rsp_data_in.count   = COUNT_W'(fill_ff);
               rsp_data_in.status  = STATUS_OK;
               rsp_data_in.last    = cnt_ff == FILL_W'(1);
               op                  = rev_ff ? CELL_ROT_UP : CELL_ROT_DOWN;
               cnt_in              = cnt_ff - FILL_W'(1);
               if (cnt_ff == FILL_W'(1)) state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (take) hold_valid_in = 1'b0;
      if (req_accept) begin
         hold_valid_in = 1'b1;
         hold_in       = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hold_valid_ff <= 1'b0;
         fill_ff       <= '0;
         rev_ff        <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         fill_ff       <= fill_in;
         rev_ff        <= rev_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hold_ff     <= hold_in;
      st_ff       <= st_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      cell_ctrl.op    = op;
      cell_ctrl.rev   = rev_ff;
      cell_ctrl.value = hold_ff.value;
      cell_ctrl.front = chain.front;
      cell_ctrl.fill  = fill_ff;
      rsp_valid       = rsp_valid_ff;
      rsp_data        = rsp_data_ff;
   end

endmodule

`default_nettype wire

// ===== sv/bounded_sorted_deque.sv =====
// ----------------------------------------------------------------------------
// bounded_sorted_deque
// ordered list of up to DEPTH signed words kept in a row of shifting cells
// ----------------------------------------------------------------------------
//
//   channel   ports                          moves
//   -------   ----------------------------   -----------------------------
//   request   req_valid req_stall req_data   one operation item (kind, value)
//   response  rsp_valid rsp_stall rsp_data   result items (element, count,
//                                            status, last)
//
// push, pop, reverse and insert first act in the idle state, where the cell
// row shifts or inserts; then the report state loads the status item into
// the output register once it is free. a dump emits one item per held
// element, the row rotating by one cell per emitted item.
// reset clears the fill count, the reverse flag and the handshake state; the
// cells themselves are left as they are.
// a one-item holding register takes the next request while a result waits
// behind a stalled response; stall on the response side halts a dump.
//
`timescale 1ns / 1ps
`default_nettype none

module bounded_sorted_deque (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  bsd_pkg::bsd_req_type  req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output bsd_pkg::bsd_rsp_type  rsp_data
);
   import bsd_pkg::*;

   // broadcast to every cell: operation, reverse flag, new value, front word, fill count
   bsd_cell_ctrl_type    cell_ctrl;
   // what each cell shows its neighbours
   bsd_cell_out_type     cell_out [DEPTH];
   bsd_chain_status_type chain;
   logic [ELEM_W-1:0]    tail_val;
   logic                 dup_any;

   bsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .chain     (chain),
      .cell_ctrl (cell_ctrl)
   );

   // the row: cell 0 is the physical bottom; with the reverse flag set the
   // logical front sits in the highest occupied cell instead
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bsd_cell_out_type left_s;
      bsd_cell_out_type right_s;

      if (i == 0) begin : g_left_edge
         assign left_s = LEFT_EDGE;
      end else begin : g_left_link
         assign left_s = cell_out[i-1];
      end

      if (i == DEPTH - 1) begin : g_right_edge
         assign right_s = RIGHT_EDGE;
      end else begin : g_right_link
         assign right_s = cell_out[i+1];
      end

      bsd_cell u_cell (
         .clock    (clock),
         .idx      (IDX_W'(i)),
         .ctrl     (cell_ctrl),
         .left     (left_s),
         .right    (right_s),
         .cell_out (cell_out[i])
      );
   end

   // pick the front word and gather the duplicate flags; tail is set in at most one cell
   always_comb begin
      tail_val = '0;
      dup_any  = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_out[i].tail) tail_val = tail_val | cell_out[i].val;
         dup_any = dup_any | cell_out[i].dup;
      end
      chain.front = cell_ctrl.rev ? tail_val : cell_out[0].val;
      chain.dup   = dup_any;
   end

endmodule

`default_nettype wire

// ===== sv/bsd_checker.sv =====
// ----------------------------------------------------------------------------
// bsd_checker
// port-level checks on the bounded sorted deque, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bsd_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_stall,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input bsd_pkg::bsd_rsp_type  rsp_data
);
   import bsd_pkg::*;

   logic rsp_held;
   logic rsp_flagged;
   logic rsp_full;
   logic rsp_empty;
   logic empty_shown;

   always_comb begin
      rsp_held    = rsp_valid && rsp_stall;
      rsp_flagged = rsp_valid && (rsp_data.status != STATUS_OK);
      rsp_full    = rsp_valid && (rsp_data.status == STATUS_FULL);
      rsp_empty   = rsp_valid && (rsp_data.status == STATUS_EMPTY);
      empty_shown = (rsp_data.count == '0) && (rsp_data.element == '0);
   end

   // a stalled result item stays put
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))

   // after reset nothing is pending on either side
   `ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid && !req_stall)

   // a flagged result item is always the last item of its operation
   `ASSERT_IMPLIES(a_flag_last, clock, reset, rsp_flagged, rsp_data.last)

   // a full flag only when the list really is full
   `ASSERT_IMPLIES(a_full_count, clock, reset, rsp_full, rsp_data.count == COUNT_W'(DEPTH))

   // an empty flag shows an empty list and a zero element
   `ASSERT_IMPLIES(a_empty_zero, clock, reset, rsp_empty, empty_shown)

endmodule

bind bounded_sorted_deque bsd_checker u_bsd_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for bounded_sorted_deque
// drives list operations through the request channel, keeps its own copy of
// the list to work out every result item, and checks each response in order
// under changing sender gaps and receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   import bsd_pkg::*;

   // kinds that the block must ignore with a plain status item
   localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
   localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

   localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;

   localparam int RANDOM_OPS    = 220;
   localparam int GROW_STRETCH  = 24;
   // longest dump plus the status path, with margin
   localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   bsd_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   bsd_rsp_type rsp_data;

   // one row of the directed script: an operation sent reps times with the
   // value stepping by one, and optionally the single result item spelt out
   typedef struct packed {
      logic [2:0]               kind;
      logic signed [ELEM_W-1:0] value;
      logic [4:0]               reps;
      logic                     typed;
      bsd_rsp_type              want;
   } script_row_type;

   localparam script_row_type SCRIPT [17] = '{
      // empty list straight after reset
      '{KIND_POP_FRONT,  32'sd0,  5'd1,  1'b1, '{32'sd0, 5'd0, STATUS_EMPTY, 1'b1}},
      '{KIND_DUMP,       32'sd0,  5'd1,  1'b1, '{32'sd0, 5'd0, STATUS_EMPTY, 1'b1}},
      '{KIND_REVERSE,    32'sd0,  5'd1,  1'b1, '{32'sd0, 5'd0, STATUS_OK, 1'b1}},
      '{KIND_UNUSED_6,   32'sd0,  5'd1,  1'b1, '{32'sd0, 5'd0, STATUS_OK, 1'b1}},
      '{KIND_UNUSED_7,   ELEM_MAX, 5'd1, 1'b1, '{32'sd0, 5'd0, STATUS_OK, 1'b1}},
      // extremes, insert ahead of a larger front, duplicate refused
      '{KIND_PUSH_FRONT, ELEM_MAX, 5'd1, 1'b1, '{ELEM_MAX, 5'd1, STATUS_OK, 1'b1}},
      '{KIND_INSERT,     32'sd0,  5'd1,  1'b0, '0},
      '{KIND_INSERT,     ELEM_MAX, 5'd1, 1'b1, '{32'sd0, 5'd2, STATUS_DUP, 1'b1}},
      '{KIND_REVERSE,    32'sd0,  5'd1,  1'b0, '0},
      '{KIND_POP_FRONT,  32'sd0,  5'd1,  1'b0, '0},
      // fill up from the most negative value
      '{KIND_PUSH_BACK,  ELEM_MIN, 5'd15, 1'b0, '0},
      // full list: pushes refused, duplicate wins over full
      '{KIND_PUSH_FRONT, 32'sd5,  5'd1,  1'b1, '{32'sd0, 5'd16, STATUS_FULL, 1'b1}},
      '{KIND_INSERT,     32'sd0,  5'd1,  1'b1, '{32'sd0, 5'd16, STATUS_DUP, 1'b1}},
      '{KIND_INSERT,     -32'sd7, 5'd1,  1'b1, '{32'sd0, 5'd16, STATUS_FULL, 1'b1}},
      '{KIND_PUSH_BACK,  32'sd1,  5'd1,  1'b1, '{32'sd0, 5'd16, STATUS_FULL, 1'b1}},
      '{KIND_DUMP,       32'sd0,  5'd1,  1'b0, '0},
      '{KIND_REVERSE,    32'sd0,  5'd1,  1'b0, '0}
   };

   // predicted list, front first, and the result items still to come
   logic signed [ELEM_W-1:0] held_list[$];
   bsd_rsp_type              pending_rsp[$];

   int req_idle_pct;
   int rsp_stall_pct;
   int mismatches;
   int results_seen;
   int ops_sent;
   int peak_fill;

   bounded_sorted_deque DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // apply one accepted operation to the predicted list and queue its results
   function automatic void apply_op(input logic [2:0] kind,
                                    input logic signed [ELEM_W-1:0] value);
      bsd_status_type st;
      int             pos;
      int             i;
      logic signed [ELEM_W-1:0] swap;
      st = STATUS_OK;
      case (kind)
         KIND_PUSH_FRONT: begin
            if (held_list.size() >= DEPTH) st = STATUS_FULL;
            else held_list.insert(0, value);
         end
         KIND_PUSH_BACK: begin
            if (held_list.size() >= DEPTH) st = STATUS_FULL;
            else held_list.insert(held_list.size(), value);
         end
         KIND_POP_FRONT: begin
            if (held_list.size() == 0) st = STATUS_EMPTY;
            else held_list.delete(0);
         end
         KIND_REVERSE: begin
            for (i = 0; i < held_list.size() / 2; i++) begin
               swap = held_list[i];
               held_list[i] = held_list[held_list.size() - 1 - i];
               held_list[held_list.size() - 1 - i] = swap;
            end
         end
         KIND_INSERT: begin
            // first element not less than the value, signed order
            pos = 0;
            while (pos < held_list.size() && held_list[pos] < value) pos++;
            if (pos < held_list.size() && held_list[pos] == value) st = STATUS_DUP;
            else if (held_list.size() >= DEPTH) st = STATUS_FULL;
            else held_list.insert(pos, value);
         end
         KIND_DUMP: begin
            if (held_list.size() == 0)
               pending_rsp.insert(pending_rsp.size(), '{32'sd0, 5'd0, STATUS_EMPTY, 1'b1});
            for (i = 0; i < held_list.size(); i++)
               pending_rsp.insert(pending_rsp.size(),
                                  '{held_list[i], COUNT_W'(held_list.size()), STATUS_OK,
                                    i == held_list.size() - 1});
            return;
         end
         default: ;
      endcase
      if (held_list.size() > peak_fill) peak_fill = held_list.size();
      pending_rsp.insert(pending_rsp.size(),
                         '{(held_list.size() != 0) ? held_list[0] : '0,
                           COUNT_W'(held_list.size()), st, 1'b1});
   endfunction

   // present one item, idling first at random, and return once it is taken
   task automatic send_op(input logic [2:0] kind, input logic signed [ELEM_W-1:0] value);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= bsd_req_type'({kind, value});
      do @(posedge clock); while (req_stall);
      apply_op(kind, value);
      ops_sent++;
   endtask

   // mostly small values so that inserts collide, some extremes, some wide
   function automatic logic signed [ELEM_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return ELEM_W'(int'($urandom_range(0, 16)) - 8);
         5: begin
            case ($urandom_range(0, 3))
               0:       return ELEM_MAX;
               1:       return ELEM_MIN;
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // growing stretches lean on pushes and inserts, shrinking ones on pops
   function automatic logic [2:0] pick_kind(input bit growing);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll >= 97) return ($urandom_range(0, 1) != 0) ? KIND_UNUSED_7 : KIND_UNUSED_6;
      if (growing) begin
         if (roll < 20) return KIND_PUSH_FRONT;
         if (roll < 40) return KIND_PUSH_BACK;
         if (roll < 70) return KIND_INSERT;
         if (roll < 80) return KIND_POP_FRONT;
         if (roll < 87) return KIND_REVERSE;
         return KIND_DUMP;
      end
      if (roll < 10) return KIND_PUSH_FRONT;
      if (roll < 20) return KIND_PUSH_BACK;
      if (roll < 35) return KIND_INSERT;
      if (roll < 75) return KIND_POP_FRONT;
      if (roll < 82) return KIND_REVERSE;
      return KIND_DUMP;
   endfunction

   task automatic report_bad(input bsd_rsp_type want, input bit orphan);
      if (mismatches < 10) begin
         if (orphan)
            $display("result %0d: unexpected item element %0d count %0d status %0d last %0d",
                     results_seen, rsp_data.element, rsp_data.count, rsp_data.status,
                     rsp_data.last);
         else
            $display("result %0d: got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d",
                     results_seen, rsp_data.element, rsp_data.count, rsp_data.status,
                     rsp_data.last, want.element, want.count, want.status, want.last);
      end
      mismatches++;
   endtask

   // receiver stall, redrawn every cycle
   always @(posedge clock)
      rsp_stall <= !reset && ($urandom_range(0, 99) < rsp_stall_pct);

   // response checker: each taken item against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_rsp.size() == 0) report_bad('0, 1'b1);
         else if (rsp_data.element !== pending_rsp[0].element
                  || rsp_data.count !== pending_rsp[0].count
                  || rsp_data.status !== pending_rsp[0].status
                  || rsp_data.last !== pending_rsp[0].last) begin
            report_bad(pending_rsp[0], 1'b0);
            pending_rsp.delete(0);
         end else begin
            pending_rsp.delete(0);
         end
      end
   end

   initial begin
      bit         growing;
      logic [2:0] kind;
      growing       = 1'b1;
      req_idle_pct  = 23;
      rsp_stall_pct = 47;
      mismatches    = 0;
      results_seen  = 0;
      ops_sent      = 0;
      peak_fill     = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed script; a spelt-out result replaces the predicted one
      foreach (SCRIPT[r]) begin
         for (int i = 0; i < SCRIPT[r].reps; i++) begin
            send_op(SCRIPT[r].kind, SCRIPT[r].value + i);
            if (SCRIPT[r].typed) pending_rsp[pending_rsp.size() - 1] = SCRIPT[r].want;
         end
      end

      // random part in three thirds: sender gaps light, then heavy, then none
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n == RANDOM_OPS / 3) begin
            req_idle_pct  = 47;
            rsp_stall_pct = 23;
         end
         if (n == 2 * RANDOM_OPS / 3) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         if (n % GROW_STRETCH == 0) growing = $urandom_range(0, 1);
         kind = pick_kind(growing);
         send_op(kind, pick_value());
      end
      req_valid <= 1'b0;

      // drain, then watch a little longer for stray items
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d operations sent (%0d from the script), %0d result items checked",
               ops_sent, ops_sent - RANDOM_OPS, results_seen);
      $display("list fill peaked at %0d of %0d, %0d bad items", peak_fill, DEPTH, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("bounded_sorted_deque: match");
      else
         $display("bounded_sorted_deque: mismatch");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("bounded_sorted_deque: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bsd_pkg.sv
sv/bsd_cell.sv
sv/bsd_ctrl.sv
sv/bounded_sorted_deque.sv
sv/bsd_checker.sv
test/testbench.sv
